@@ hdl/gbts_pkg.sv @@
// Shared types, field widths and codes for the gap buffer text store.
package gbts_pkg;

    localparam int DEPTH_DEF = 4096;
    localparam int MAX_RUN   = 64;

    localparam int KIND_W = 2;
    localparam int POS_W  = 13;
    localparam int CHAR_W = 16;
    localparam int CNT_W  = 7;
    localparam int ST_W   = 2;

    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [ST_W-1:0]   t_status;

    localparam t_kind KIND_INSERT = 2'd0;
    localparam t_kind KIND_DELETE = 2'd1;
    localparam t_kind KIND_READ   = 2'd2;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_BAD_POS   = 2'd1;
    localparam t_status ST_BAD_RANGE = 2'd2;
    localparam t_status ST_FULL      = 2'd3;

    // A checked command handed from the front end to the sequencer.
    // For a read, cnt already holds the clipped number of characters.
    typedef struct packed {
        t_kind              kind;
        t_status            status;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   end_position;
        logic [CHAR_W-1:0]  fill_char;
        logic [CNT_W-1:0]   cnt;
    } t_cmd;

    // One result word as produced by the sequencer.
    typedef struct packed {
        t_status            status;
        logic               has_char;
        logic [CHAR_W-1:0]  char_value;
        logic [POS_W-1:0]   text_len;
        logic               last;
    } t_res;

endpackage

@@ hdl/gbts_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
module gbts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/gbts_seq.sv @@
// Sequencer: gap moves, fills, deletes and reads against the text RAM.
module gbts_seq #(
    parameter int DEPTH = gbts_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  gbts_pkg::t_cmd                      i_cmd,
    output logic                                o_idle,
    input  logic                                i_out_free,
    output logic                                o_push,
    output gbts_pkg::t_res                      o_res,
    output logic [$clog2(DEPTH+1)-1:0]          o_len,
    output logic [$clog2(DEPTH+1)-1:0]          o_gap_start,
    output logic [$clog2(DEPTH+1)-1:0]          o_gap_end,
    output logic                                o_ram_we,
    output logic [$clog2(DEPTH)-1:0]            o_ram_waddr,
    output logic [gbts_pkg::CHAR_W-1:0]         o_ram_wdata,
    output logic                                o_ram_re,
    output logic [$clog2(DEPTH)-1:0]            o_ram_raddr,
    input  logic [gbts_pkg::CHAR_W-1:0]         i_ram_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH+1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOVE,
        S_FILL,
        S_DEL,
        S_RD_ISSUE,
        S_RD_WAIT,
        S_RESP
    } t_state;

    t_state                        r_state;
    t_state                        r_next;
    logic [LW-1:0]                 r_gs;
    logic [LW-1:0]                 r_ge;
    logic [LW-1:0]                 r_len;
    logic [LW-1:0]                 r_tgt;
    logic [LW-1:0]                 r_del_n;
    logic [LW-1:0]                 r_rd_pos;
    logic [gbts_pkg::CNT_W-1:0]    r_left;
    logic [gbts_pkg::CHAR_W-1:0]   r_ch;
    gbts_pkg::t_status             r_status;
    logic                          r_wr_pend;
    logic [AW-1:0]                 r_wr_addr;

    logic [LW-1:0] w_gs_m1;
    logic [LW-1:0] w_ge_m1;
    logic [LW-1:0] w_rd_phys;
    logic          w_mv_left;
    logic          w_mv_right;
    logic          w_last_one;

    assign w_gs_m1    = r_gs - LW'(1);
    assign w_ge_m1    = r_ge - LW'(1);
    assign w_mv_left  = (r_state == S_MOVE) && (r_gs > r_tgt);
    assign w_mv_right = (r_state == S_MOVE) && (r_gs < r_tgt);
    assign w_rd_phys  = (r_rd_pos < r_gs) ? r_rd_pos : r_rd_pos + (r_ge - r_gs);
    assign w_last_one = (r_left == gbts_pkg::CNT_W'(1));

    // A left move carries the character below the gap to its top end; a right
    // move carries the character above the gap to its bottom end. The write
    // comes in the cycle after its read and never touches a later read address.
    always_comb begin
        o_ram_re    = 1'b0;
        o_ram_raddr = r_ge[AW-1:0];
        if (w_mv_left) begin
            o_ram_re    = 1'b1;
            o_ram_raddr = w_gs_m1[AW-1:0];
        end else if (w_mv_right) begin
            o_ram_re    = 1'b1;
            o_ram_raddr = r_ge[AW-1:0];
        end else if ((r_state == S_RD_ISSUE) && i_out_free) begin
            o_ram_re    = 1'b1;
            o_ram_raddr = w_rd_phys[AW-1:0];
        end
    end

    assign o_ram_we    = r_wr_pend || (r_state == S_FILL);
    assign o_ram_waddr = r_wr_pend ? r_wr_addr : r_gs[AW-1:0];
    assign o_ram_wdata = r_wr_pend ? i_ram_rdata : r_ch;

    always_comb begin
        o_push           = 1'b0;
        o_res.status     = r_status;
        o_res.has_char   = 1'b0;
        o_res.char_value = '0;
        o_res.text_len   = gbts_pkg::POS_W'(r_len);
        o_res.last       = 1'b1;
        case (r_state)
            S_RESP: begin
                o_push = i_out_free;
            end
            S_RD_WAIT: begin
                o_push           = 1'b1;
                o_res.status     = gbts_pkg::ST_OK;
                o_res.has_char   = 1'b1;
                o_res.char_value = i_ram_rdata;
                o_res.last       = w_last_one;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_gs      <= '0;
            r_ge      <= LW'(DEPTH);
            r_len     <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            r_wr_pend <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_status <= i_cmd.status;
                        r_ch     <= i_cmd.fill_char;
                        r_left   <= i_cmd.cnt;
                        r_tgt    <= LW'(i_cmd.position);
                        r_rd_pos <= LW'(i_cmd.position);
                        r_del_n  <= LW'(i_cmd.end_position) - LW'(i_cmd.position);
                        r_state  <= S_RESP;
                        if (i_cmd.status == gbts_pkg::ST_OK) begin
                            case (i_cmd.kind)
                                gbts_pkg::KIND_INSERT: begin
                                    if (i_cmd.cnt != '0) begin
                                        r_next  <= S_FILL;
                                        r_state <= S_MOVE;
                                    end
                                end
                                gbts_pkg::KIND_DELETE: begin
                                    r_next  <= S_DEL;
                                    r_state <= S_MOVE;
                                end
                                gbts_pkg::KIND_READ: begin
                                    if (i_cmd.cnt != '0) begin
                                        r_state <= S_RD_ISSUE;
                                    end
                                end
                                default: begin
                                    r_state <= S_RESP;
                                end
                            endcase
                        end
                    end
                end
                S_MOVE: begin
                    if (w_mv_left) begin
                        r_wr_pend <= 1'b1;
                        r_wr_addr <= w_ge_m1[AW-1:0];
                        r_gs      <= w_gs_m1;
                        r_ge      <= w_ge_m1;
                    end else if (w_mv_right) begin
                        r_wr_pend <= 1'b1;
                        r_wr_addr <= r_gs[AW-1:0];
                        r_gs      <= r_gs + LW'(1);
                        r_ge      <= r_ge + LW'(1);
                    end else begin
                        r_state <= r_next;
                    end
                end
                S_FILL: begin
                    r_gs   <= r_gs + LW'(1);
                    r_len  <= r_len + LW'(1);
                    r_left <= r_left - gbts_pkg::CNT_W'(1);
                    if (w_last_one) begin
                        r_state <= S_RESP;
                    end
                end
                S_DEL: begin
                    r_ge    <= r_ge + r_del_n;
                    r_len   <= r_len - r_del_n;
                    r_state <= S_RESP;
                end
                S_RD_ISSUE: begin
                    if (i_out_free) begin
                        r_state <= S_RD_WAIT;
                    end
                end
                S_RD_WAIT: begin
                    r_rd_pos <= r_rd_pos + LW'(1);
                    r_left   <= r_left - gbts_pkg::CNT_W'(1);
                    r_state  <= w_last_one ? S_IDLE : S_RD_ISSUE;
                end
                S_RESP: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_len       = r_len;
    assign o_gap_start = r_gs;
    assign o_gap_end   = r_ge;

endmodule

@@ hdl/gap_buffer_text_store_unit.sv @@
// Sequence: an insert or delete first moves the gap to its position, character by character;
// then an insert writes its characters into the gap and a delete moves the gap end past the range.
// A rejected item, the spare kind or a zero-count insert or read goes straight to its result;
// a read issues one RAM read at a time and passes each character on before it issues the next.
// Throughput: one item at a time; input ready returns with the last result, and a full output
// register stalls the sequencer. Reset clears the gap pointers and length, not the text RAM.
module gap_buffer_text_store_unit #(
    parameter int DEPTH = gbts_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input words.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // position[12:0], end_position[25:13], fill_char[41:26], count[48:42], zero pad
    input  logic [55:0] i_s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    // Result words.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // status[1:0], char_value[17:2], text_length_now[30:18], zero pad
    output logic [31:0] o_m_axis_tdata,
    // has_char[0]
    output logic        o_m_axis_tuser,
    output logic        o_m_axis_tlast
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH+1);
    // Compare width that holds both a position field and the length, plus a carry.
    localparam int CW = ((LW > gbts_pkg::POS_W) ? LW : gbts_pkg::POS_W) + 1;

    // Unpacked input fields.
    gbts_pkg::t_kind                 w_kind;
    logic [gbts_pkg::POS_W-1:0]      w_pos;
    logic [gbts_pkg::POS_W-1:0]      w_end;
    logic [gbts_pkg::CHAR_W-1:0]     w_char;
    logic [gbts_pkg::CNT_W-1:0]      w_count;

    assign w_kind  = i_s_axis_tuser;
    assign w_pos   = i_s_axis_tdata[12:0];
    assign w_end   = i_s_axis_tdata[25:13];
    assign w_char  = i_s_axis_tdata[41:26];
    assign w_count = i_s_axis_tdata[48:42];

    // Sequencer and RAM hookup.
    logic                            w_idle;
    logic                            w_start;
    logic                            w_out_free;
    logic                            w_push;
    gbts_pkg::t_cmd                  w_cmd;
    gbts_pkg::t_res                  w_res;
    logic [LW-1:0]                   w_len;
    logic [LW-1:0]                   w_gs;
    logic [LW-1:0]                   w_ge;
    logic                            w_ram_we;
    logic [AW-1:0]                   w_ram_waddr;
    logic [gbts_pkg::CHAR_W-1:0]     w_ram_wdata;
    logic                            w_ram_re;
    logic [AW-1:0]                   w_ram_raddr;
    logic [gbts_pkg::CHAR_W-1:0]     w_ram_rdata;

    // Front-end checks, done combinationally against the current length.
    logic [gbts_pkg::CNT_W-1:0]      w_cnt_cl;
    logic [gbts_pkg::CNT_W-1:0]      w_rd_n;
    logic [CW-1:0]                   w_pos_c;
    logic [CW-1:0]                   w_end_c;
    logic [CW-1:0]                   w_len_c;
    logic [CW-1:0]                   w_avail;
    logic                            w_pos_bad;
    logic                            w_end_bad;
    logic                            w_full;
    gbts_pkg::t_status               w_status;

    // Output register, the only buffer between the sequencer and the result side.
    logic                            r_out_valid;
    gbts_pkg::t_res                  r_out;

    assign w_cnt_cl  = (w_count > gbts_pkg::CNT_W'(gbts_pkg::MAX_RUN))
                     ? gbts_pkg::CNT_W'(gbts_pkg::MAX_RUN) : w_count;
    assign w_pos_c   = CW'(w_pos);
    assign w_end_c   = CW'(w_end);
    assign w_len_c   = CW'(w_len);
    assign w_pos_bad = (w_pos_c > w_len_c);
    assign w_end_bad = (w_end_c > w_len_c);
    assign w_full    = ((w_len_c + CW'(w_cnt_cl)) > CW'(DEPTH));
    // Characters left after the read start; only meaningful when the start is valid.
    assign w_avail   = w_len_c - w_pos_c;
    assign w_rd_n    = (w_avail < CW'(w_cnt_cl)) ? gbts_pkg::CNT_W'(w_avail) : w_cnt_cl;

    always_comb begin
        w_status = gbts_pkg::ST_OK;
        case (w_kind)
            gbts_pkg::KIND_INSERT: begin
                // A zero-count insert is accepted without any position check.
                if (w_cnt_cl != '0) begin
                    if (w_pos_bad) begin
                        w_status = gbts_pkg::ST_BAD_POS;
                    end else if (w_full) begin
                        w_status = gbts_pkg::ST_FULL;
                    end
                end
            end
            gbts_pkg::KIND_DELETE: begin
                if (w_pos_bad || w_end_bad) begin
                    w_status = gbts_pkg::ST_BAD_POS;
                end else if (w_pos_c > w_end_c) begin
                    w_status = gbts_pkg::ST_BAD_RANGE;
                end
            end
            gbts_pkg::KIND_READ: begin
                if (w_pos_bad) begin
                    w_status = gbts_pkg::ST_BAD_POS;
                end
            end
            default: begin
                w_status = gbts_pkg::ST_OK;
            end
        endcase
    end

    assign w_cmd.kind         = w_kind;
    assign w_cmd.status       = w_status;
    assign w_cmd.position     = w_pos;
    assign w_cmd.end_position = w_end;
    assign w_cmd.fill_char    = w_char;
    assign w_cmd.cnt          = (w_kind == gbts_pkg::KIND_READ) ? w_rd_n : w_cnt_cl;

    // The sequencer takes a new word whenever it is idle, even while the
    // previous result still sits in the output register.
    assign o_s_axis_tready = w_idle;
    assign w_start         = i_s_axis_tvalid && w_idle;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    gbts_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_cmd        (w_cmd),
        .o_idle       (w_idle),
        .i_out_free   (w_out_free),
        .o_push       (w_push),
        .o_res        (w_res),
        .o_len        (w_len),
        .o_gap_start  (w_gs),
        .o_gap_end    (w_ge),
        .o_ram_we     (w_ram_we),
        .o_ram_waddr  (w_ram_waddr),
        .o_ram_wdata  (w_ram_wdata),
        .o_ram_re     (w_ram_re),
        .o_ram_raddr  (w_ram_raddr),
        .i_ram_rdata  (w_ram_rdata)
    );

    // The text store: one write and one registered read per cycle.
    gbts_ram #(
        .WIDTH (gbts_pkg::CHAR_W),
        .DEPTH (DEPTH)
    ) u_text_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out.text_len, r_out.char_value, r_out.status};
    assign o_m_axis_tuser  = r_out.has_char;
    assign o_m_axis_tlast  = r_out.last;

    // Text plus gap always fills the whole store.
    a_gap_sum : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((LW+1)'(w_len) + (LW+1)'(w_ge) - (LW+1)'(w_gs)) == (LW+1)'(DEPTH))
        else $error("gap pointers and length disagree");

    // A pending result is never overwritten.
    a_no_overrun : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (!r_out_valid || i_m_axis_tready))
        else $error("result pushed into a full output register");

    // Every accepted word keeps the block busy for at least the next cycle.
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken again right after an accept");

    // A word without a character is always the only result of its item.
    a_single_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> o_m_axis_tlast)
        else $error("status-only result without last");

endmodule

@@ tb/sv/gap_buffer_text_store_unit_tb.sv @@
// Self-checking testbench for the gap buffer text store: edits and reads against a text model.
module gap_buffer_text_store_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The block is built with its default store size.
    localparam int STORE_DEPTH = gbts_pkg::DEPTH_DEF;

    // The spare kind code is not named in the package; the block answers it with a plain OK.
    localparam gbts_pkg::t_kind KIND_UNUSED = 2'd3;

    // The longest quiet stretch of a correct run is a gap move across the whole store,
    // a full insert run and the long receiver hold-off, plus sender gaps. The limit is
    // several times that.
    localparam int WATCHDOG_LIMIT = 30000;
    // After the last result word the bench keeps watching the bus so that a stray extra word is caught.
    localparam int DRAIN_CYCLES   = 200;
    // Long receiver hold-off, and the number of accepted edits that trigger each one.
    localparam int HOLD_CYCLES    = 400;
    localparam int FIRST_HOLD_AT  = 30;
    localparam int SECOND_HOLD_AT = 110;

    // One input word as the block sees it.
    typedef struct packed {
        gbts_pkg::t_kind                kind;
        logic [gbts_pkg::POS_W-1:0]     position;
        logic [gbts_pkg::POS_W-1:0]     end_position;
        logic [gbts_pkg::CHAR_W-1:0]    fill_char;
        logic [gbts_pkg::CNT_W-1:0]     count;
    } t_edit;

    // Receiver behavior between hold-offs.
    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_TOGGLE} t_rx_mode;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_valid = 1'b0;
    logic [55:0] s_data  = '0;
    logic [1:0]  s_user  = '0;
    logic        m_ready = 1'b0;

    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        o_m_axis_tlast;

    // Edits waiting for the driver, and the one on the bus right now.
    t_edit       pending_edits[$];
    t_edit       offered_edit;

    // Text model: the logical text in order, without any gap.
    logic [gbts_pkg::CHAR_W-1:0] text_chars[$];
    // Result words still owed by the block, oldest first.
    gbts_pkg::t_res              expected_words[$];

    // Length and cursor as the stimulus generator expects them after the queued edits.
    int          plan_len = 0;
    int          cursor   = 0;

    bit          in_taken  = 1'b0;
    bit          out_taken = 1'b0;
    int          edits_accepted  = 0;
    int          words_checked   = 0;
    int          mismatch_count  = 0;
    int          idle_cycles     = 0;

    int          gap_left   = 0;
    int          burst_left = 4;

    t_rx_mode    rx_mode      = RX_ALWAYS;
    int          rx_mode_left = 0;
    int          hold_left    = 0;
    int          holds_done   = 0;

    gap_buffer_text_store_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        // position[12:0], end_position[25:13], fill_char[41:26], count[48:42], zero pad
        .i_s_axis_tdata  (s_data),
        // kind[1:0]
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        // status[1:0], char_value[17:2], text_length_now[30:18], zero pad
        .o_m_axis_tdata  (o_m_axis_tdata),
        // has_char[0]
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Queue one result word whose text length is the current model length.
    task automatic owe_word(gbts_pkg::t_status status, logic has_char,
                            logic [gbts_pkg::CHAR_W-1:0] ch, logic last);
        gbts_pkg::t_res w;
        w.status     = status;
        w.has_char   = has_char;
        w.char_value = ch;
        w.text_len   = gbts_pkg::POS_W'(text_chars.size());
        w.last       = last;
        expected_words.push_back(w);
    endtask

    // Apply one accepted edit to the text model and queue the words it must produce.
    task automatic apply_edit_to_text(t_edit e);
        int unsigned len;
        int unsigned pos;
        int unsigned endp;
        int unsigned run;
        int unsigned n;
        len  = text_chars.size();
        pos  = e.position;
        endp = e.end_position;
        run  = (e.count > gbts_pkg::MAX_RUN) ? gbts_pkg::MAX_RUN : e.count;
        case (e.kind)
            gbts_pkg::KIND_INSERT: begin
                // A zero count is a no-op, even at a position past the end of the text.
                if (run == 0) begin
                    owe_word(gbts_pkg::ST_OK, 1'b0, '0, 1'b1);
                end else if (pos > len) begin
                    owe_word(gbts_pkg::ST_BAD_POS, 1'b0, '0, 1'b1);
                end else if (len + run > STORE_DEPTH) begin
                    owe_word(gbts_pkg::ST_FULL, 1'b0, '0, 1'b1);
                end else begin
                    repeat (run) text_chars.insert(pos, e.fill_char);
                    owe_word(gbts_pkg::ST_OK, 1'b0, '0, 1'b1);
                end
            end
            gbts_pkg::KIND_DELETE: begin
                if (pos > len || endp > len) begin
                    owe_word(gbts_pkg::ST_BAD_POS, 1'b0, '0, 1'b1);
                end else if (pos > endp) begin
                    owe_word(gbts_pkg::ST_BAD_RANGE, 1'b0, '0, 1'b1);
                end else begin
                    repeat (endp - pos) text_chars.delete(pos);
                    owe_word(gbts_pkg::ST_OK, 1'b0, '0, 1'b1);
                end
            end
            gbts_pkg::KIND_READ: begin
                if (pos > len) begin
                    owe_word(gbts_pkg::ST_BAD_POS, 1'b0, '0, 1'b1);
                end else begin
                    // The read is clipped at the end of the text.
                    n = (len - pos < run) ? len - pos : run;
                    if (n == 0) begin
                        owe_word(gbts_pkg::ST_OK, 1'b0, '0, 1'b1);
                    end else begin
                        for (int unsigned i = 0; i < n; i++) begin
                            owe_word(gbts_pkg::ST_OK, 1'b1, text_chars[pos + i], i + 1 == n);
                        end
                    end
                end
            end
            default: begin
                owe_word(gbts_pkg::ST_OK, 1'b0, '0, 1'b1);
            end
        endcase
    endtask

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("%0t: result word %0d, %s: got 0x%0h, expected 0x%0h",
                 $realtime, words_checked, what, got, want);
        mismatch_count++;
    endtask

    // Compare the word on the result bus with the oldest one owed.
    task automatic check_result_word();
        gbts_pkg::t_res want;
        if (expected_words.size() == 0) begin
            report_mismatch("word with nothing owed", o_m_axis_tdata, 0);
        end else begin
            want = expected_words.pop_front();
            if (o_m_axis_tdata[1:0] !== want.status)
                report_mismatch("status", o_m_axis_tdata[1:0], want.status);
            if (o_m_axis_tuser !== want.has_char)
                report_mismatch("has_char", o_m_axis_tuser, want.has_char);
            if (o_m_axis_tdata[17:2] !== want.char_value)
                report_mismatch("char_value", o_m_axis_tdata[17:2], want.char_value);
            if (o_m_axis_tdata[30:18] !== want.text_len)
                report_mismatch("text_length_now", o_m_axis_tdata[30:18], want.text_len);
            if (o_m_axis_tlast !== want.last)
                report_mismatch("last", o_m_axis_tlast, want.last);
        end
        words_checked++;
    endtask

    // Queue an edit and track the length and cursor that it leaves behind, so that later
    // edits can aim at positions that are valid at the time they reach the block.
    task automatic queue_item(gbts_pkg::t_kind kind, int pos, int endp, int ch, int cnt);
        t_edit e;
        e.kind         = kind;
        e.position     = gbts_pkg::POS_W'(pos);
        e.end_position = gbts_pkg::POS_W'(endp);
        e.fill_char    = gbts_pkg::CHAR_W'(ch);
        e.count        = gbts_pkg::CNT_W'(cnt);
        pending_edits.push_back(e);
        if (kind == gbts_pkg::KIND_INSERT && cnt != 0 && pos <= plan_len
                && plan_len + cnt <= STORE_DEPTH) begin
            plan_len += cnt;
            cursor = pos + cnt;
        end else if (kind == gbts_pkg::KIND_DELETE && pos <= plan_len && endp <= plan_len
                && pos <= endp) begin
            plan_len -= endp - pos;
            cursor = pos;
        end
    endtask

    // Most edits land near the cursor, as in ordinary typing; some jump anywhere.
    function automatic int pick_position();
        int p;
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, plan_len);
        p = cursor + $urandom_range(0, 16) - 8;
        if (p < 0) p = 0;
        if (p > plan_len) p = plan_len;
        return p;
    endfunction

    // A position past the end of the text, where one exists.
    function automatic int far_position();
        return (plan_len >= STORE_DEPTH) ? STORE_DEPTH
                                         : $urandom_range(plan_len + 1, STORE_DEPTH);
    endfunction

    // One random edit: mostly well-formed, with some bad positions, reversed ranges,
    // zero counts and the spare kind mixed in.
    task automatic queue_random_edit();
        int unsigned roll;
        int pos;
        int endp;
        int cnt;
        roll = $urandom_range(0, 99);
        pos  = pick_position();
        if (roll < 40) begin
            cnt = ($urandom_range(0, 9) == 0) ? gbts_pkg::MAX_RUN : $urandom_range(1, 16);
            queue_item(gbts_pkg::KIND_INSERT, pos, $urandom_range(0, STORE_DEPTH),
                       $urandom_range(0, 65535), cnt);
        end else if (roll < 62) begin
            endp = pos + $urandom_range(0, 16);
            if (endp > plan_len) endp = plan_len;
            queue_item(gbts_pkg::KIND_DELETE, pos, endp, $urandom_range(0, 65535),
                       $urandom_range(0, 64));
        end else if (roll < 90) begin
            cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom_range(1, 12);
            queue_item(gbts_pkg::KIND_READ, pos, $urandom_range(0, STORE_DEPTH),
                       $urandom_range(0, 65535), cnt);
        end else begin
            case ($urandom_range(0, 4))
                0: queue_item(gbts_pkg::KIND_INSERT, far_position(),
                              $urandom_range(0, STORE_DEPTH), $urandom_range(0, 65535),
                              $urandom_range(1, 64));
                1: begin
                    if (plan_len > 0) begin
                        pos = $urandom_range(1, plan_len);
                        queue_item(gbts_pkg::KIND_DELETE, pos, $urandom_range(0, pos - 1),
                                   $urandom_range(0, 65535), $urandom_range(0, 64));
                    end else begin
                        queue_item(gbts_pkg::KIND_DELETE, 0, 1, 0, 0);
                    end
                end
                2: queue_item(gbts_pkg::KIND_DELETE, pos, far_position(),
                              $urandom_range(0, 65535), $urandom_range(0, 64));
                3: queue_item(gbts_pkg::KIND_READ, far_position(),
                              $urandom_range(0, STORE_DEPTH), $urandom_range(0, 65535),
                              $urandom_range(0, 64));
                default: begin
                    if ($urandom_range(0, 1) == 0)
                        queue_item(KIND_UNUSED, $urandom_range(0, STORE_DEPTH),
                                   $urandom_range(0, STORE_DEPTH), $urandom_range(0, 65535),
                                   $urandom_range(0, 64));
                    else
                        queue_item(gbts_pkg::KIND_INSERT, $urandom_range(0, STORE_DEPTH),
                                   $urandom_range(0, STORE_DEPTH), $urandom_range(0, 65535),
                                   0);
                end
            endcase
        end
    endtask

    // Stimulus and end of run.
    initial begin
        int pos;
        int endp;

        // Directed part, starting from the empty text.
        queue_item(gbts_pkg::KIND_READ,   0, 0, 0, 5);         // read of an empty text
        queue_item(gbts_pkg::KIND_DELETE, 0, 0, 0, 0);         // empty range on an empty text
        queue_item(gbts_pkg::KIND_INSERT, 1, 0, 16'h1234, 3);  // insert past the end
        queue_item(gbts_pkg::KIND_INSERT, STORE_DEPTH, STORE_DEPTH, 16'hFFFF, 0); // zero count
        queue_item(gbts_pkg::KIND_INSERT, 0, 0, 16'hFFFF, gbts_pkg::MAX_RUN);
        // In front of existing text.
        queue_item(gbts_pkg::KIND_INSERT, 0, 0, 16'h0000, gbts_pkg::MAX_RUN);
        queue_item(gbts_pkg::KIND_INSERT, 64, 0, 16'hA5A5, 1);   // in the middle
        queue_item(gbts_pkg::KIND_INSERT, 129, 0, 16'h5A5A, 2);  // at the very end
        queue_item(gbts_pkg::KIND_READ,   0, 0, 0, gbts_pkg::MAX_RUN);
        // Clipped at the end of the text.
        queue_item(gbts_pkg::KIND_READ,   126, 0, 0, gbts_pkg::MAX_RUN);
        queue_item(gbts_pkg::KIND_READ,   131, 0, 0, 1);         // position equal to the length
        queue_item(gbts_pkg::KIND_READ,   132, 0, 0, 1);         // position past the end
        queue_item(gbts_pkg::KIND_READ,   STORE_DEPTH, 0, 0, 0); // past the end, zero count
        queue_item(gbts_pkg::KIND_READ,   10, 0, 0, 0);          // zero count
        queue_item(gbts_pkg::KIND_DELETE, STORE_DEPTH, 0, 0, 0); // start past the end
        queue_item(gbts_pkg::KIND_DELETE, 0, STORE_DEPTH, 0, 0); // end past the end
        queue_item(gbts_pkg::KIND_DELETE, 20, 10, 0, 0);         // reversed range
        queue_item(gbts_pkg::KIND_DELETE, 60, 70, 0, 0);
        queue_item(gbts_pkg::KIND_DELETE, 5, 5, 0, 0);           // empty range still moves the gap
        queue_item(KIND_UNUSED, 8191, 8191, 16'hFFFF, 127);
        queue_item(gbts_pkg::KIND_DELETE, 0, 121, 0, 0);         // whole text
        queue_item(gbts_pkg::KIND_INSERT, 0, 0, 16'h8001, 33);
        queue_item(gbts_pkg::KIND_READ,   0, 0, 0, 63);

        // Random edits around a moving cursor.
        repeat (20) queue_random_edit();

        // Fill the store to the last entry, mostly near the cursor so gap moves stay short,
        // then overflow it, read its tail and cut it back down with long deletes.
        while (plan_len + gbts_pkg::MAX_RUN <= STORE_DEPTH)
            queue_item(gbts_pkg::KIND_INSERT, pick_position(), 0, $urandom_range(0, 65535),
                       gbts_pkg::MAX_RUN);
        if (plan_len < STORE_DEPTH)
            queue_item(gbts_pkg::KIND_INSERT, pick_position(), 0, $urandom_range(0, 65535),
                       STORE_DEPTH - plan_len);
        queue_item(gbts_pkg::KIND_INSERT, pick_position(), 0, $urandom_range(0, 65535), 1);
        queue_item(gbts_pkg::KIND_INSERT, 0, 0, $urandom_range(0, 65535), gbts_pkg::MAX_RUN);
        queue_item(gbts_pkg::KIND_READ, STORE_DEPTH - 3, 0, 0, gbts_pkg::MAX_RUN);
        queue_item(gbts_pkg::KIND_READ, $urandom_range(0, STORE_DEPTH - gbts_pkg::MAX_RUN),
                   0, 0, gbts_pkg::MAX_RUN);
        queue_item(gbts_pkg::KIND_READ, STORE_DEPTH, 0, 0, gbts_pkg::MAX_RUN);
        while (plan_len > 200) begin
            pos  = $urandom_range(0, plan_len / 2);
            endp = pos + $urandom_range(64, 1024);
            if (endp > plan_len) endp = plan_len;
            queue_item(gbts_pkg::KIND_DELETE, pos, endp, 0, 0);
            queue_item(gbts_pkg::KIND_READ, pick_position(), 0, 0, $urandom_range(1, 8));
        end

        repeat (10) queue_random_edit();

        // Reset, released at a falling edge.
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // Wait for the driver to hand over every edit, then for every owed word.
        while (pending_edits.size() != 0 || s_valid) @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("gap_buffer_text_store_unit_tb passed");
        end else begin
            $display("gap_buffer_text_store_unit_tb failed");
        end
        $finish;
    end

    // Driver: words go out in bursts with random gaps; a word stays on the bus until taken.
    always @(negedge i_clk) begin
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (gap_left != 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_edits.size() != 0) begin
                offered_edit = pending_edits.pop_front();
                s_data  <= {7'd0, offered_edit.count, offered_edit.fill_char,
                            offered_edit.end_position, offered_edit.position};
                s_user  <= offered_edit.kind;
                s_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    // About half the bursts run straight into the next one.
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: a few stall patterns in turn, and twice a long hold-off while the sender
    // keeps offering, so that the block backs up and drops its input ready.
    always @(negedge i_clk) begin
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_left == 0 && holds_done < 2
                    && edits_accepted >= (holds_done == 0 ? FIRST_HOLD_AT : SECOND_HOLD_AT)) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode      = t_rx_mode'($urandom_range(0, 3));
                    rx_mode_left = $urandom_range(8, 64);
                end
                rx_mode_left--;
                case (rx_mode)
                    RX_ALWAYS: m_ready <= 1'b1;
                    RX_RANDOM: m_ready <= $urandom_range(0, 1);
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= ~m_ready;
                endcase
            end
        end
    end

    // Monitor: at each rising edge, predict for an accepted edit, check a taken result
    // word, and keep the watchdog on quiet cycles.
    always @(posedge i_clk) begin
        in_taken  = rst_n && s_valid && o_s_axis_tready;
        out_taken = rst_n && o_m_axis_tvalid && m_ready;
        if (in_taken) begin
            apply_edit_to_text(offered_edit);
            edits_accepted++;
        end
        if (out_taken) begin
            check_result_word();
        end
        if (!rst_n || in_taken || out_taken) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $realtime, idle_cycles);
            $display("gap_buffer_text_store_unit_tb failed");
            $finish;
        end
    end

endmodule
